// File: hdl/tes_pkg.sv
// Shared constants, codes and control types of the token entropy scorer.
package tes_pkg;

  localparam int MAX_SEQ_DEF      = 4096;
  localparam int VOCAB_DEPTH_DEF  = 32768;
  localparam int MAX_CHANNELS_DEF = 256;

  localparam int TPC_W      = 13;
  localparam int VOC_REG_W  = 16;
  localparam int NCH_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NCH = 2'd2;

  localparam logic [TPC_W-1:0]     TPC_RST = 13'd1;
  localparam logic [VOC_REG_W-1:0] VOC_RST = 16'd32000;
  localparam logic [NCH_W-1:0]     NCH_RST = 9'd1;

  localparam int TAG_W     = 9;
  localparam int SUM_W     = 48;
  localparam int LN_W      = 32;
  localparam int LN_FRAC_W = 28;
  localparam int LN_SHIFT  = 36;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam int SCORE_W   = 16;
  localparam int SCORE_ONE = 32768;
  localparam int TE_FLAT   = 8192;
  localparam int Q14_SHIFT = 14;
  localparam int OUT_CH_W  = 8;

  typedef enum logic [1:0] {LN_COUNT, LN_LEN, LN_MIN} ln_sel_e;
  typedef enum logic [1:0] {DS_MEAN, DS_TE, DS_TU} div_sel_e;

  typedef struct packed {
    logic     clr_init;
    logic     clr_step;
    logic     tok_load;
    logic     mem_read;
    logic     look_load;
    logic     ln_start;
    ln_sel_e  ln_sel;
    logic     term_load;
    logic     hist_upd;
    logic     pos_step;
    logic     lnl_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     mean_load;
    logic     te_load;
    logic     te_const;
    logic     score_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic tok_ok;
    logic ln_done;
    logic div_done;
    logic chan_end;
    logic m_le1;
    logic clr_last;
    logic epoch_wrap;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/tes_ln.sv
// Iterative natural log unit: ln(n) in Q8.24 by repeated squaring, one bit per cycle.
module tes_ln #(
  parameter int IN_W = 13
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [IN_W-1:0]          n_i,
  output logic                     done_o,
  output logic [tes_pkg::LN_W-1:0] res_o
);

  localparam int KW     = (IN_W > 1) ? $clog2(IN_W) : 1;
  localparam int FRAC_W = tes_pkg::LN_FRAC_W;
  localparam int CW     = $clog2(FRAC_W);
  localparam int PW     = KW + FRAC_W + 32;

  typedef enum logic [2:0] {
    LN_IDLE = 3'b001,
    LN_ITER = 3'b010,
    LN_MUL  = 3'b100
  } ln_state_e;

  ln_state_e state_q, state_d;
  logic [CW-1:0]      cnt_q;
  logic               done_q;
  logic [KW-1:0]      k, k_q;
  logic [30:0]        y_q, y_next;
  logic [FRAC_W-1:0]  frac_q;
  logic [IN_W+29:0]   y_wide;
  logic [61:0]        sq;
  logic [31:0]        s;
  logic [PW-1:0]      prod;
  logic [tes_pkg::LN_W-1:0] res_q;

  // Position of the leading one; zero and one both give k = 0 and a zero log.
  always_comb begin
    k = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (n_i[b]) k = KW'(b);
    end
  end

  assign y_wide = {n_i, 30'b0} >> k;
  assign sq     = 62'(y_q) * 62'(y_q);
  assign s      = sq[61:30];
  assign y_next = s[31] ? s[31:1] : s[30:0];
  assign prod   = PW'({k_q, frac_q}) * PW'(tes_pkg::LN2_Q32);

  always_comb begin
    state_d = state_q;
    case (state_q)
      LN_IDLE: if (start_i) state_d = LN_ITER;
      LN_ITER: if (cnt_q == CW'(FRAC_W - 1)) state_d = LN_MUL;
      LN_MUL:  state_d = LN_IDLE;
      default: state_d = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == LN_MUL);
      if (state_q == LN_IDLE) cnt_q <= '0;
      else if (state_q == LN_ITER) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == LN_IDLE && start_i) begin
      k_q <= k;
      y_q <= y_wide[30:0];
    end else if (state_q == LN_ITER) begin
      y_q    <= y_next;
      frac_q <= {frac_q[FRAC_W-2:0], s[31]};
    end
    if (state_q == LN_MUL) res_q <= tes_pkg::LN_W'(prod >> tes_pkg::LN_SHIFT);
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hdl/tes_div.sv
// Restoring divider, one quotient bit per cycle.
module tes_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tes_pkg::SUM_W-1:0] dvd_i,
  input  logic [tes_pkg::LN_W-1:0]  dvs_i,
  output logic                      done_o,
  output logic [tes_pkg::SUM_W-1:0] quo_o
);

  localparam int DVD_W = tes_pkg::SUM_W;
  localparam int DVS_W = tes_pkg::LN_W;
  localparam int CW    = $clog2(DVD_W);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q, rem_d;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/tes_dp.sv
// Datapath: configuration, histogram memory, log and divide units, scoring and output word.
module tes_dp #(
  parameter int MAX_SEQ      = tes_pkg::MAX_SEQ_DEF,
  parameter int VOCAB_DEPTH  = tes_pkg::VOCAB_DEPTH_DEF,
  parameter int MAX_CHANNELS = tes_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [31:0]                    token_id_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [7:0]                     channel_number_o,
  output logic [15:0]                    score_q15_o,
  output logic [7:0]                     best_channel_o,
  output logic                           run_done_o,
  input  tes_pkg::cmd_t                  cmd_i,
  output tes_pkg::stat_t                 stat_o
);

  localparam int LEN_W = $clog2(MAX_SEQ + 1);
  localparam int VA_W  = $clog2(VOCAB_DEPTH);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int TAG_W = tes_pkg::TAG_W;
  localparam int SUM_W = tes_pkg::SUM_W;
  localparam int LN_W  = tes_pkg::LN_W;
  localparam int SC_W  = tes_pkg::SCORE_W;

  typedef struct packed {
    logic [LEN_W-1:0] cnt;
    logic [TAG_W-1:0] tag;
    logic [SUM_W-1:0] term;
  } hist_word_t;

  // Configuration registers and their clamped values.
  logic [tes_pkg::TPC_W-1:0]     tpc_q;
  logic [tes_pkg::VOC_REG_W-1:0] voc_q;
  logic [tes_pkg::NCH_W-1:0]     nch_q;
  logic [31:0] tpc32, voc32, nch32, len32, vlim32, nlim32, m32;
  logic [LEN_W-1:0] len_eff, m_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q <= tes_pkg::TPC_RST;
      voc_q <= tes_pkg::VOC_RST;
      nch_q <= tes_pkg::NCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tes_pkg::CFG_TPC: tpc_q <= cfg_wdata_i[tes_pkg::TPC_W-1:0];
        tes_pkg::CFG_VOC: voc_q <= cfg_wdata_i[tes_pkg::VOC_REG_W-1:0];
        tes_pkg::CFG_NCH: nch_q <= cfg_wdata_i[tes_pkg::NCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign tpc32  = 32'(tpc_q);
  assign voc32  = 32'(voc_q);
  assign nch32  = 32'(nch_q);
  assign len32  = (tpc32 == '0) ? 32'd1 : ((tpc32 > 32'(MAX_SEQ)) ? 32'(MAX_SEQ) : tpc32);
  assign vlim32 = (voc32 == '0) ? 32'd1
                : ((voc32 > 32'(VOCAB_DEPTH)) ? 32'(VOCAB_DEPTH) : voc32);
  assign nlim32 = (nch32 == '0) ? 32'd1
                : ((nch32 > 32'(MAX_CHANNELS)) ? 32'(MAX_CHANNELS) : nch32);
  assign m32     = (len32 < vlim32) ? len32 : vlim32;
  assign len_eff = len32[LEN_W-1:0];
  assign m_eff   = m32[LEN_W-1:0];

  // Token word and its validity.
  logic [31:0]     tok_q;
  logic [VA_W-1:0] idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) tok_q <= token_id_i;
  end

  assign idx = tok_q[VA_W-1:0];

  // Histogram memory with epoch tags; a stale tag reads as an empty entry.
  hist_word_t       hist_mem [VOCAB_DEPTH];
  hist_word_t       rd_q, wr_word;
  logic [VA_W-1:0]  clr_addr_q;
  logic [TAG_W-1:0] epoch_q;
  logic             hit;
  logic [LEN_W-1:0] c_eff, c1_comb, c1_q;
  logic             new_q;
  logic [SUM_W-1:0] old_q, term_q;

  assign hit     = (rd_q.tag == epoch_q);
  assign c_eff   = hit ? rd_q.cnt : '0;
  assign c1_comb = c_eff + LEN_W'(1);

  always_comb begin
    wr_word.cnt  = c1_q;
    wr_word.tag  = epoch_q;
    wr_word.term = term_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) hist_mem[clr_addr_q] <= '0;
    else if (cmd_i.hist_upd) hist_mem[idx] <= wr_word;
    if (cmd_i.mem_read) rd_q <= hist_mem[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_addr_q <= '0;
    else if (cmd_i.clr_init) clr_addr_q <= '0;
    else if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + VA_W'(1);
  end

  // Log and divide units.
  logic [LEN_W-1:0]  ln_n;
  logic              ln_done, div_done;
  logic [LN_W-1:0]   ln_res;
  logic [SUM_W-1:0]  dvd, quo;
  logic [LN_W-1:0]   dvs;

  always_comb begin
    case (cmd_i.ln_sel)
      tes_pkg::LN_COUNT: ln_n = c1_comb;
      tes_pkg::LN_LEN:   ln_n = len_eff;
      tes_pkg::LN_MIN:   ln_n = m_eff;
      default:           ln_n = len_eff;
    endcase
  end

  tes_ln #(.IN_W(LEN_W)) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ln_start),
    .n_i     (ln_n),
    .done_o  (ln_done),
    .res_o   (ln_res)
  );

  logic [TAG_W-1:0] unused_tag;
  logic [LEN_W-1:0] unique_q, pos_q;
  logic [SUM_W-1:0] sum_q;
  logic [LN_W-1:0]  lnl_q, h_q;

  assign unused_tag = '0;

  always_comb begin
    case (cmd_i.div_sel)
      tes_pkg::DS_MEAN: begin
        dvd = sum_q;
        dvs = LN_W'(len_eff);
      end
      tes_pkg::DS_TE: begin
        dvd = SUM_W'({h_q, tes_pkg::Q14_SHIFT'(0)});
        dvs = ln_res;
      end
      tes_pkg::DS_TU: begin
        dvd = SUM_W'({unique_q, tes_pkg::Q14_SHIFT'(0)});
        dvs = LN_W'(len_eff);
      end
      default: begin
        dvd = sum_q;
        dvs = LN_W'(len_eff);
      end
    endcase
  end

  tes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (dvd),
    .dvs_i   (dvs),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Per-token bookkeeping and channel-end arithmetic.
  logic [LEN_W:0]   pos_next;
  logic [SUM_W-1:0] te_q;
  logic [SUM_W:0]   tot;
  logic [SC_W-1:0]  score_q, top_score_q;
  logic [CH_W-1:0]  chan_q, best_ch_q, best_ch_d;
  logic             best_upd, last_ch;
  logic [31:0]      chan32, best32;

  assign pos_next = {1'b0, pos_q} + (LEN_W+1)'(1);
  assign tot      = (SUM_W+1)'(te_q) + (SUM_W+1)'(quo);
  assign best_upd = (chan_q == '0) || (score_q > top_score_q);
  assign best_ch_d = best_upd ? chan_q : best_ch_q;
  assign last_ch  = (32'(chan_q) + 32'd1) >= nlim32;
  assign chan32   = 32'(chan_q);
  assign best32   = 32'(best_ch_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_load) begin
      c1_q  <= c1_comb;
      new_q <= (c_eff == '0);
      old_q <= hit ? rd_q.term : '0;
    end
    if (cmd_i.term_load) term_q <= SUM_W'(c1_q) * SUM_W'(ln_res);
    if (cmd_i.lnl_load) lnl_q <= ln_res;
    if (cmd_i.mean_load) h_q <= (quo < SUM_W'(lnl_q)) ? lnl_q - quo[LN_W-1:0] : '0;
    if (cmd_i.te_load) te_q <= cmd_i.te_const ? SUM_W'(tes_pkg::TE_FLAT) : quo;
    if (cmd_i.score_load) begin
      score_q <= (tot > (SUM_W+1)'(tes_pkg::SCORE_ONE)) ? SC_W'(tes_pkg::SCORE_ONE)
                                                         : tot[SC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q      <= TAG_W'(1);
      unique_q     <= '0;
      sum_q        <= '0;
      pos_q        <= '0;
      chan_q       <= '0;
      best_ch_q    <= '0;
      top_score_q  <= '0;
    end else begin
      if (cmd_i.hist_upd) begin
        sum_q    <= sum_q + term_q - old_q;
        unique_q <= unique_q + LEN_W'(new_q);
      end
      if (cmd_i.pos_step) begin
        pos_q <= (pos_next >= {1'b0, len_eff}) ? '0 : pos_next[LEN_W-1:0];
      end
      if (cmd_i.out_load) begin
        best_ch_q    <= best_ch_d;
        top_score_q  <= best_upd ? score_q : top_score_q;
        chan_q       <= last_ch ? '0 : chan_q + CH_W'(1);
        epoch_q      <= (epoch_q == '1) ? TAG_W'(1) : epoch_q + TAG_W'(1);
        unique_q     <= '0;
        sum_q        <= '0;
      end
    end
  end

  // Output word register.
  logic       out_valid_q;
  logic [7:0] ch_out_q, best_out_q;
  logic [15:0] score_out_q;
  logic       done_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ch_out_q    <= chan32[tes_pkg::OUT_CH_W-1:0];
      score_out_q <= score_q;
      best_out_q  <= best32[tes_pkg::OUT_CH_W-1:0];
      done_out_q  <= last_ch;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_number_o = ch_out_q;
  assign score_q15_o      = score_out_q;
  assign best_channel_o   = best_out_q;
  assign run_done_o       = done_out_q;

  always_comb begin
    stat_o.tok_ok     = !tok_q[31] && ({1'b0, tok_q[30:0]} < vlim32) && (unused_tag == '0);
    stat_o.ln_done    = ln_done;
    stat_o.div_done   = div_done;
    stat_o.chan_end   = (pos_next >= {1'b0, len_eff});
    stat_o.m_le1      = (m32 <= 32'd1);
    stat_o.clr_last   = (clr_addr_q == VA_W'(VOCAB_DEPTH - 1));
    stat_o.epoch_wrap = (epoch_q == '1);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

// File: hdl/tes_ctrl.sv
// Controller: sequences the clearing pass, each token's histogram update and the channel score.
module tes_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output tes_pkg::cmd_t  cmd_o,
  input  tes_pkg::stat_t stat_i
);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_READ  = 13'b0000000000100,
    ST_LOOK  = 13'b0000000001000,
    ST_LNC   = 13'b0000000010000,
    ST_UPD   = 13'b0000000100000,
    ST_POS   = 13'b0000001000000,
    ST_LNL   = 13'b0000010000000,
    ST_DMEAN = 13'b0000100000000,
    ST_LNM   = 13'b0001000000000,
    ST_DTE   = 13'b0010000000000,
    ST_DTU   = 13'b0100000000000,
    ST_SCORE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.tok_load = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (stat_i.tok_ok) begin
          cmd_o.mem_read = 1'b1;
          state_d = ST_LOOK;
        end else begin
          state_d = ST_POS;
        end
      end
      ST_LOOK: begin
        cmd_o.look_load = 1'b1;
        cmd_o.ln_start  = 1'b1;
        cmd_o.ln_sel    = tes_pkg::LN_COUNT;
        state_d = ST_LNC;
      end
      ST_LNC: begin
        if (stat_i.ln_done) begin
          cmd_o.term_load = 1'b1;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.hist_upd = 1'b1;
        state_d = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos_step = 1'b1;
        if (stat_i.chan_end) begin
          cmd_o.ln_start = 1'b1;
          cmd_o.ln_sel   = tes_pkg::LN_LEN;
          state_d = ST_LNL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LNL: begin
        if (stat_i.ln_done) begin
          cmd_o.lnl_load  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tes_pkg::DS_MEAN;
          state_d = ST_DMEAN;
        end
      end
      ST_DMEAN: begin
        if (stat_i.div_done) begin
          cmd_o.mean_load = 1'b1;
          if (stat_i.m_le1) begin
            cmd_o.te_load   = 1'b1;
            cmd_o.te_const  = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = tes_pkg::DS_TU;
            state_d = ST_DTU;
          end else begin
            cmd_o.ln_start = 1'b1;
            cmd_o.ln_sel   = tes_pkg::LN_MIN;
            state_d = ST_LNM;
          end
        end
      end
      ST_LNM: begin
        cmd_o.ln_sel = tes_pkg::LN_MIN;
        if (stat_i.ln_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tes_pkg::DS_TE;
          state_d = ST_DTE;
        end
      end
      ST_DTE: begin
        if (stat_i.div_done) begin
          cmd_o.te_load   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tes_pkg::DS_TU;
          state_d = ST_DTU;
        end
      end
      ST_DTU: begin
        if (stat_i.div_done) begin
          cmd_o.score_load = 1'b1;
          state_d = ST_SCORE;
        end
      end
      ST_SCORE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          // The tag epoch runs out here, so every tag is wiped before the next token.
          if (stat_i.epoch_wrap) begin
            cmd_o.clr_init = 1'b1;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

endmodule

// File: hdl/token_entropy_scorer.sv
// Top level of the token entropy scorer.
// Scores channels of token ids by normalized Shannon entropy plus distinct-token ratio and
// reports, at each channel end, the channel's Q1.15 score and the best channel of the run.
// After reset, and again after every 511th channel, a clearing pass over all VOCAB_DEPTH
// entries wipes the histogram tags while no word is taken. A token that is out of range
// skips the histogram and only steps the position; a counted token runs the iterative log
// unit (28 squaring steps) around one histogram read-modify-write. The last token of a
// channel adds one log and two divisions when min(L,V) is one, else two logs and three
// divisions, then the output step, plus any wait for the output register to free up.
module token_entropy_scorer #(
  parameter int MAX_SEQ      = tes_pkg::MAX_SEQ_DEF,
  parameter int VOCAB_DEPTH  = tes_pkg::VOCAB_DEPTH_DEF,
  parameter int MAX_CHANNELS = tes_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [31:0]             token_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     channel_number_o,
  output logic [15:0]                    score_q15_o,
  output logic [7:0]                     best_channel_o,
  output logic                           run_done_o
);

  tes_pkg::cmd_t  cmd;
  tes_pkg::stat_t stat;

  tes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  tes_dp #(
    .MAX_SEQ      (MAX_SEQ),
    .VOCAB_DEPTH  (VOCAB_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .token_id_i       (token_id_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .channel_number_o (channel_number_o),
    .score_q15_o      (score_q15_o),
    .best_channel_o   (best_channel_o),
    .run_done_o       (run_done_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

endmodule

// File: hdl/tes_checker.sv
// Port-level checks of the token entropy scorer and their binding to the top level.
module tes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  channel_number_o,
  input logic [15:0] score_q15_o,
  input logic [7:0]  best_channel_o,
  input logic        run_done_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_number_o)
      && $stable(score_q15_o) && $stable(best_channel_o) && $stable(run_done_o))
    else $error("result word changed while stalled");

  // One token is worked on at a time.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second token taken back to back");

  // Scores never exceed one.
  a_score_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_q15_o <= 16'd32768)
    else $error("score above one");

  // A new result only comes out of the scoring step, never while tokens are being taken.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while input was open");

endmodule

bind token_entropy_scorer tes_checker u_tes_checker (.*);

// File: bench/token_entropy_scorer_test.sv
// Self-checking testbench of the token entropy scorer with its own score predictor.
module token_entropy_scorer_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 300;
  localparam int SPREAD_DEF  = 12;

  typedef struct {
    logic [7:0]  chan;
    logic [15:0] score;
    logic [7:0]  best;
    logic        done;
  } score_word_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [tes_pkg::CFG_IDX_W-1:0]  cfg_idx_i = tes_pkg::CFG_TPC;
  logic [tes_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic signed [31:0]             token_id_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [7:0]                     channel_number_o;
  logic [15:0]                    score_q15_o;
  logic [7:0]                     best_channel_o;
  logic                           run_done_o;

  token_entropy_scorer dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state, mirroring the block.
  int unsigned        len_reg = tes_pkg::TPC_RST;
  int unsigned        vocab_reg = tes_pkg::VOC_RST;
  int unsigned        chans_reg = tes_pkg::NCH_RST;
  int unsigned        token_hist[int unsigned];
  int unsigned        distinct_cnt = 0;
  longint unsigned    clog_sum = 0;
  int unsigned        position = 0;
  int unsigned        chan_idx = 0;
  int                 top_score = -1;
  int unsigned        best_chan = 0;

  logic signed [31:0] token_q[$];
  score_word_t        score_q[$];
  int                 tx_max = 14;
  int                 rx_max = 14;
  int                 hold_req = 0;
  int                 mismatches = 0;
  int                 n_sent = 0;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned ln_fix(int unsigned n);
    int unsigned     k;
    longint unsigned y;
    longint unsigned l2;
    k = 0;
    if (n < 2) return 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    y = (64'(n) << 30) >> k;
    l2 = 64'(k) << tes_pkg::LN_FRAC_W;
    for (int i = tes_pkg::LN_FRAC_W - 1; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        l2 = l2 | (64'd1 << i);
      end
    end
    return (l2 * 64'(tes_pkg::LN2_Q32)) >> tes_pkg::LN_SHIFT;
  endfunction

  // Counts one accepted token and queues the score word when it closes a channel.
  task automatic count_token(logic signed [31:0] tok);
    int unsigned     len;
    int unsigned     voc;
    int unsigned     nch;
    int unsigned     c;
    int unsigned     m;
    int unsigned     score;
    longint unsigned lnl;
    longint unsigned mean;
    longint unsigned h;
    longint unsigned te;
    longint unsigned tu;
    score_word_t     w;
    len = clamp_reg(len_reg, tes_pkg::MAX_SEQ_DEF);
    voc = clamp_reg(vocab_reg, tes_pkg::VOCAB_DEPTH_DEF);
    nch = clamp_reg(chans_reg, tes_pkg::MAX_CHANNELS_DEF);
    if (tok >= 0 && int'(tok) < int'(voc)) begin
      c = token_hist.exists(tok) ? token_hist[tok] : 0;
      if (c == 0) distinct_cnt++;
      clog_sum = clog_sum - 64'(c) * ln_fix(c);
      c++;
      clog_sum = clog_sum + 64'(c) * ln_fix(c);
      token_hist[tok] = c;
    end
    position++;
    if (position < len) return;
    lnl = ln_fix(len);
    mean = clog_sum / len;
    h = (mean < lnl) ? lnl - mean : 0;
    m = (len < voc) ? len : voc;
    if (m <= 1) te = tes_pkg::TE_FLAT;
    else te = (h << tes_pkg::Q14_SHIFT) / ln_fix(m);
    tu = (64'(distinct_cnt) << tes_pkg::Q14_SHIFT) / len;
    score = (te + tu > tes_pkg::SCORE_ONE) ? tes_pkg::SCORE_ONE : int'(te + tu);
    if (chan_idx == 0) top_score = -1;
    if (int'(score) > top_score) begin
      top_score = score;
      best_chan = chan_idx;
    end
    w.chan = chan_idx[7:0];
    w.score = score[15:0];
    w.best = best_chan[7:0];
    w.done = (chan_idx + 1 >= nch);
    score_q.push_back(w);
    chan_idx = w.done ? 0 : chan_idx + 1;
    position = 0;
    distinct_cnt = 0;
    clog_sum = 0;
    token_hist.delete();
  endtask

  // Sender: one word offered at a time, with a random gap after each.
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) count_token(token_id_i);
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          in_valid_i <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (token_q.size() != 0) begin
          token_id_i <= token_q.pop_front();
          in_valid_i <= 1'b1;
          tx_gap <= $urandom_range(0, tx_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word and stalls at random, with a long hold on request.
  int rx_wait = 0;
  int hold_cnt = 0;
  int hold_seen = 0;
  int cycles = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    int          nxt;
    score_word_t w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout with %0d words still expected", score_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (score_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: chan %0d score %0d", channel_number_o, score_q15_o);
        end else begin
          w = score_q.pop_front();
          if (channel_number_o !== w.chan || score_q15_o !== w.score ||
              best_channel_o !== w.best || run_done_o !== w.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp chan %0d score %0d best %0d done %0d, got %0d %0d %0d %0d",
                       w.chan, w.score, w.best, w.done,
                       channel_number_o, score_q15_o, best_channel_o, run_done_o);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_cnt <= 3000;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        nxt = $urandom_range(0, rx_max);
        rx_wait <= nxt;
        out_stall_i <= (nxt != 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_stall_i <= (rx_wait > 1);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [tes_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data[tes_pkg::CFG_DATA_W-1:0];
    case (idx)
      tes_pkg::CFG_TPC: len_reg = data & 32'h1FFF;
      tes_pkg::CFG_VOC: vocab_reg = data & 32'hFFFF;
      tes_pkg::CFG_NCH: chans_reg = data & 32'h1FF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every word is sent and scored, then lets the block settle.
  task automatic drain();
    @(negedge clk_i);
    while (token_q.size() != 0 || in_valid_i || score_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic send(logic signed [31:0] tok);
    n_sent++;
    token_q.push_back(tok);
  endtask

  // Mostly ids from a narrow range so counts repeat, the rest spread or ignored.
  function automatic logic signed [31:0] pick_token(int unsigned spread);
    int unsigned voc;
    int unsigned r;
    voc = clamp_reg(vocab_reg, tes_pkg::VOCAB_DEPTH_DEF);
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, ((spread < voc) ? spread : voc) - 1);
    if (r < 80) return $urandom_range(0, voc - 1);
    if (r < 85) return voc + $urandom_range(0, 3);
    if (r < 93) return $urandom | 32'h80000000;
    return $urandom & 32'h7FFFFFFF;
  endfunction

  initial begin
    int unsigned len;
    int unsigned nch;
    int unsigned r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: every token closes a channel of one, flat entropy term.
    send(0); send(31999); send(32000); send(-1); send(32'h7FFFFFFF); send(32'h80000000);
    drain();
    // Zero registers act as one.
    write_reg(tes_pkg::CFG_TPC, 0); write_reg(tes_pkg::CFG_VOC, 0);
    write_reg(tes_pkg::CFG_NCH, 0);
    send(0); send(5);
    drain();
    // Three channels of four, including a run end and repeated ids.
    write_reg(tes_pkg::CFG_TPC, 4); write_reg(tes_pkg::CFG_VOC, 3);
    write_reg(tes_pkg::CFG_NCH, 3);
    send(0); send(0); send(0); send(0);
    send(0); send(1); send(2); send(1);
    send(5); send(-3); send(2); send(2);
    drain();
    // Length shortened below the current position: the next token ends the channel.
    write_reg(tes_pkg::CFG_TPC, 6); write_reg(tes_pkg::CFG_NCH, 2);
    send(1); send(2); send(1); send(0);
    drain();
    write_reg(tes_pkg::CFG_TPC, 3);
    send(2);
    drain();
    // Oversized vocabulary register, top id counted.
    write_reg(tes_pkg::CFG_VOC, 16'hFFFF); write_reg(tes_pkg::CFG_TPC, 2);
    send(32767); send(32768);
    drain();

    // Back pressure: long receiver hold while the sender keeps going.
    write_reg(tes_pkg::CFG_TPC, 1); write_reg(tes_pkg::CFG_NCH, 5);
    write_reg(tes_pkg::CFG_VOC, 40);
    tx_max = 0;
    hold_req++;
    repeat (40) send(pick_token(SPREAD_DEF));
    drain();

    // Oversized length held open for a while, then shortened so the next token closes it.
    write_reg(tes_pkg::CFG_TPC, 16'h1FFF); write_reg(tes_pkg::CFG_VOC, 16'hFFFF);
    write_reg(tes_pkg::CFG_NCH, 1);
    tx_max = 2;
    for (int i = 0; i < 200; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send($urandom_range(0, 30));
      else if (r < 60) send($urandom_range(0, 32767));
      else send($urandom | 32'h80000000);
    end
    drain();
    write_reg(tes_pkg::CFG_TPC, 150);
    send(7);
    drain();

    // Enough one-token channels to wrap the histogram epoch, with the widest run.
    write_reg(tes_pkg::CFG_TPC, 1); write_reg(tes_pkg::CFG_NCH, 16'h1FF);
    write_reg(tes_pkg::CFG_VOC, 100);
    tx_max = 14;
    repeat (520) send(pick_token(SPREAD_DEF));
    drain();

    while (n_sent < 1800) begin
      r = $urandom_range(0, 9);
      len = (r < 3) ? $urandom_range(1, 3) : (r < 8) ? $urandom_range(1, 24)
          : (r < 9) ? 0 : $urandom_range(25, 60);
      write_reg(tes_pkg::CFG_TPC, len);
      r = $urandom_range(0, 9);
      write_reg(tes_pkg::CFG_VOC, (r < 5) ? $urandom_range(1, 64) : (r < 6) ? 0 :
                         (r < 7) ? 16'hFFFF : (r < 8) ? 32000 : $urandom_range(1, 65535));
      r = $urandom_range(0, 9);
      nch = (r < 6) ? $urandom_range(1, 8) : (r < 7) ? 0 : (r < 8) ? 16'h1FF
          : $urandom_range(9, 300);
      write_reg(tes_pkg::CFG_NCH, nch);
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      // Sometimes a partial channel is left open across the next register writes.
      repeat ($urandom_range(1, 8) * clamp_reg(len, tes_pkg::MAX_SEQ_DEF)
              + $urandom_range(0, 1))
        send(pick_token($urandom_range(1, 20)));
      drain();
    end

    mismatches += score_q.size();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
